### src/assert_macros.svh
// assertion macros shared by the glyph expander modules
// no dependencies; include after the timescale line

`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, masked while reset is held
`define GTR_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, masked while reset is held
`define GTR_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/gtr_pkg.sv
// shared types and constants for the 2bpp glyph to rgb565 expander
// no dependencies; imported by every module of the block

`timescale 1ns / 1ps

package gtr_pkg;

    // glyph staging limits and screen size
    localparam int GLYPH_MAX_W = 20;
    localparam int GLYPH_MAX_H = 24;
    localparam int SCREEN_W    = 240;
    localparam int SCREEN_H    = 320;

    // entries of the queue between front and back, at least 2
    localparam int QUEUE_DEPTH = 2;

    localparam int APB_ADDR_W = 3;

    // input and result kinds
    localparam logic KIND_HEADER = 1'b0;
    localparam logic KIND_BYTE   = 1'b1;

    // header status codes
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_EMPTY      = 2'd1;
    localparam logic [1:0] ST_TOO_LARGE  = 2'd2;
    localparam logic [1:0] ST_OFF_SCREEN = 2'd3;

    // register index, taken from paddr bit 2
    localparam logic REG_FG = 1'b0;
    localparam logic REG_BG = 1'b1;

    localparam logic [15:0] FG_RESET = 16'hFFFF;
    localparam logic [15:0] BG_RESET = 16'h0000;

    // one classified word waiting for the back end
    typedef struct packed {
        logic       kind;
        logic [1:0] status;
        logic [9:0] rect_x;
        logic [9:0] rect_y;
        logic [7:0] coverage;
        logic [2:0] count;      // pixels to emit, 1 to 4
        logic       glyph_end;  // final pixel of this word closes the glyph
    } t_entry;

endpackage

### src/gtr_front.sv
// front end: takes words, checks headers, tracks the glyph column and row
// depends on gtr_pkg and assert_macros.svh

`timescale 1ns / 1ps
`include "assert_macros.svh"

module gtr_front import gtr_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_kind,
    input  logic [5:0]         i_glyph_width,
    input  logic [5:0]         i_glyph_height,
    input  logic signed [16:0] i_pen_x,
    input  logic signed [7:0]  i_offset_x,
    input  logic signed [15:0] i_baseline_y,
    input  logic signed [7:0]  i_offset_y,
    input  logic [7:0]         i_bitmap_byte,
    input  logic               i_q_full,
    output logic               o_push,
    output t_entry             o_entry
);

    localparam logic [5:0]         MAX_W    = 6'(GLYPH_MAX_W);
    localparam logic [5:0]         MAX_H    = 6'(GLYPH_MAX_H);
    localparam logic signed [18:0] SCR_W_S  = 19'(SCREEN_W);
    localparam logic signed [17:0] SCR_H_S  = 18'(SCREEN_H);

    logic       r_active, n_active;
    logic [5:0] r_width, n_width;
    logic [5:0] r_height, n_height;
    logic [5:0] r_column, n_column;
    logic [5:0] r_row, n_row;

    logic               accept;
    logic signed [17:0] x_pos;
    logic signed [16:0] y_pos;
    logic signed [18:0] x_end;
    logic signed [17:0] y_end;
    logic [1:0]         status;
    logic [5:0]         remain;
    logic [2:0]         count;
    logic [5:0]         col_next;
    logic [5:0]         row_next;
    logic               wrap;
    logic               done;

    assign o_ready = !i_q_full;
    assign accept  = i_valid && o_ready;

    // rectangle placement
    always_comb begin
        x_pos = 18'(i_pen_x) + 18'(i_offset_x);
        y_pos = 17'(i_baseline_y) + 17'(i_offset_y);
        x_end = 19'(x_pos) + signed'({13'd0, i_glyph_width});
        y_end = 18'(y_pos) + signed'({12'd0, i_glyph_height});
        if (i_glyph_width == 6'd0 || i_glyph_height == 6'd0) begin
            status = ST_EMPTY;
        end else if (i_glyph_width > MAX_W || i_glyph_height > MAX_H) begin
            status = ST_TOO_LARGE;
        end else if (x_pos < 0 || y_pos < 0 || x_end > SCR_W_S || y_end > SCR_H_S) begin
            status = ST_OFF_SCREEN;
        end else begin
            status = ST_OK;
        end
    end

    // pixels this byte covers before the row ends
    always_comb begin
        remain   = r_width - r_column;
        count    = (remain > 6'd3) ? 3'd4 : remain[2:0];
        col_next = r_column + 6'(count);
        wrap     = (col_next >= r_width);
        row_next = r_row + 6'd1;
        done     = wrap && (row_next >= r_height);
    end

    always_comb begin
        o_entry.kind      = i_kind;
        o_entry.status    = (i_kind == KIND_HEADER) ? status : ST_OK;
        o_entry.rect_x    = (i_kind == KIND_HEADER && status == ST_OK) ? x_pos[9:0] : 10'd0;
        o_entry.rect_y    = (i_kind == KIND_HEADER && status == ST_OK) ? y_pos[9:0] : 10'd0;
        o_entry.coverage  = i_bitmap_byte;
        o_entry.count     = (i_kind == KIND_HEADER) ? 3'd1 : count;
        o_entry.glyph_end = (i_kind == KIND_BYTE) && done;
        o_push            = accept && (i_kind == KIND_HEADER || r_active);
    end

    always_comb begin
        n_active = r_active;
        n_width  = r_width;
        n_height = r_height;
        n_column = r_column;
        n_row    = r_row;
        if (accept) begin
            if (i_kind == KIND_HEADER) begin
                // a new header abandons any unfinished glyph
                n_active = (status == ST_OK);
                if (status == ST_OK) begin
                    n_width  = i_glyph_width;
                    n_height = i_glyph_height;
                    n_column = 6'd0;
                    n_row    = 6'd0;
                end
            end else if (r_active) begin
                n_column = wrap ? 6'd0 : col_next;
                if (wrap) begin
                    n_row = done ? 6'd0 : row_next;
                end
                if (done) begin
                    n_active = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_width  <= 6'd0;
            r_height <= 6'd0;
            r_column <= 6'd0;
            r_row    <= 6'd0;
        end else begin
            r_active <= n_active;
            r_width  <= n_width;
            r_height <= n_height;
            r_column <= n_column;
            r_row    <= n_row;
        end
    end

    `GTR_ASSERT_IMP(a_column_in_row, i_clk, i_rst_n, r_active,
        (r_column < r_width) && (r_row < r_height), "glyph position past its size")

endmodule

### src/gtr_fifo.sv
// short queue of classified words between front and back ends
// depends on gtr_pkg and assert_macros.svh

`timescale 1ns / 1ps
`include "assert_macros.svh"

module gtr_fifo import gtr_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_wdata,
    input  logic   i_pop,
    output logic   o_valid,
    output logic   o_full,
    output t_entry o_rdata
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] LAST_P  = PTR_W'(QUEUE_DEPTH - 1);

    t_entry           r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == DEPTH_C);
    assign o_rdata = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_P) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_P) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    `GTR_ASSERT_IMP(a_no_overflow, i_clk, i_rst_n, i_push, !o_full, "push into full queue")
    `GTR_ASSERT_NEXT(a_push_fills, i_clk, i_rst_n, i_push && !i_pop, o_valid,
        "queue empty after push")

endmodule

### src/gtr_back.sv
// back end: expands queued words into results with the palette, one per cycle while the receiver is ready
// depends on gtr_pkg and assert_macros.svh

`timescale 1ns / 1ps
`include "assert_macros.svh"

module gtr_back import gtr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [15:0] i_fg,
    input  logic [15:0] i_bg,
    input  logic        i_q_valid,
    input  t_entry      i_q_entry,
    output logic        o_pop,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_out_kind,
    output logic [1:0]  o_status,
    output logic [9:0]  o_rect_x,
    output logic [9:0]  o_rect_y,
    output logic [15:0] o_pixel_color,
    output logic        o_glyph_end,
    output logic        o_last
);

    // v / 3 for v below 192: (v * 171) >> 9
    function automatic logic [5:0] div3(input logic [7:0] v);
        logic [15:0] prod;
        prod = 16'(v) * 16'd171;
        return prod[14:9];
    endfunction

    // channel blend weighted two to one toward a
    function automatic logic [5:0] mix(input logic [5:0] a, input logic [5:0] b);
        logic [7:0] sum;
        sum = {1'b0, a, 1'b0} + {2'b00, b};
        return div3(sum);
    endfunction

    logic [15:0] r_mix1;    // coverage 1: one third ink
    logic [15:0] r_mix2;    // coverage 2: two thirds ink
    logic [1:0]  r_k;
    logic        r_valid;
    logic        r_kind;
    logic [1:0]  r_status;
    logic [9:0]  r_rect_x;
    logic [9:0]  r_rect_y;
    logic [15:0] r_color;
    logic        r_glyph_end;
    logic        r_last;

    logic        load;
    logic        item_last;
    logic [1:0]  cov;
    logic [15:0] color;
    logic [5:0]  m1_r, m1_g, m1_b, m2_r, m2_g, m2_b;

    always_comb begin
        m1_r = mix({1'b0, i_bg[15:11]}, {1'b0, i_fg[15:11]});
        m1_g = mix(i_bg[10:5], i_fg[10:5]);
        m1_b = mix({1'b0, i_bg[4:0]}, {1'b0, i_fg[4:0]});
        m2_r = mix({1'b0, i_fg[15:11]}, {1'b0, i_bg[15:11]});
        m2_g = mix(i_fg[10:5], i_bg[10:5]);
        m2_b = mix({1'b0, i_fg[4:0]}, {1'b0, i_bg[4:0]});
    end

    always_ff @(posedge i_clk) begin
        r_mix1 <= {m1_r[4:0], m1_g, m1_b[4:0]};
        r_mix2 <= {m2_r[4:0], m2_g, m2_b[4:0]};
    end

    // coverage pair for the current pixel, leftmost pair first
    always_comb begin
        case (r_k)
            2'd0:    cov = i_q_entry.coverage[7:6];
            2'd1:    cov = i_q_entry.coverage[5:4];
            2'd2:    cov = i_q_entry.coverage[3:2];
            default: cov = i_q_entry.coverage[1:0];
        endcase
        case (cov)
            2'd0:    color = i_bg;
            2'd1:    color = r_mix1;
            2'd2:    color = r_mix2;
            default: color = i_fg;
        endcase
    end

    assign load      = i_q_valid && (!r_valid || i_ready);
    assign item_last = (i_q_entry.kind == KIND_HEADER) || (3'(r_k) + 3'd1 == i_q_entry.count);
    assign o_pop     = load && item_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_k     <= 2'd0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_k     <= item_last ? 2'd0 : r_k + 2'd1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_kind      <= i_q_entry.kind;
            r_last      <= item_last;
            if (i_q_entry.kind == KIND_HEADER) begin
                r_status    <= i_q_entry.status;
                r_rect_x    <= i_q_entry.rect_x;
                r_rect_y    <= i_q_entry.rect_y;
                r_color     <= 16'd0;
                r_glyph_end <= 1'b0;
            end else begin
                r_status    <= ST_OK;
                r_rect_x    <= 10'd0;
                r_rect_y    <= 10'd0;
                r_color     <= color;
                r_glyph_end <= item_last && i_q_entry.glyph_end;
            end
        end
    end

    assign o_valid       = r_valid;
    assign o_out_kind    = r_kind;
    assign o_status      = r_status;
    assign o_rect_x      = r_rect_x;
    assign o_rect_y      = r_rect_y;
    assign o_pixel_color = r_color;
    assign o_glyph_end   = r_glyph_end;
    assign o_last        = r_last;

    `GTR_ASSERT_IMP(a_end_is_last, i_clk, i_rst_n, r_valid && r_glyph_end, r_last,
        "glyph end on a result that is not last")
    `GTR_ASSERT_IMP(a_k_in_range, i_clk, i_rst_n,
        i_q_valid && i_q_entry.kind == KIND_BYTE, 3'(r_k) < i_q_entry.count,
        "pixel index past byte count")

endmodule

### src/glyph_2bpp_to_rgb565_expander.sv
// top level of the 2bpp glyph to rgb565 expander: apb registers and wiring
// depends on gtr_pkg, gtr_front, gtr_fifo, gtr_back and assert_macros.svh

`timescale 1ns / 1ps

// A glyph is sent as one header word (size, pen position, offsets) followed by
// its 2bpp bitmap bytes, row by row. The header always gives exactly one result:
// a status (accepted, empty, too large, off screen) and, when accepted, the
// top-left screen corner of the glyph. Each byte of an accepted glyph gives one
// to four rgb565 pixels, leftmost pair first; pairs past the row width are
// dropped, and bytes with no accepted glyph give nothing. The pixel color comes
// from a four-entry palette: background, one-third and two-thirds blends per
// channel (truncated), and foreground. The last result of every word carries
// last, and the final pixel of a glyph also carries glyph_end.
// Timing: a word is taken whenever the two-entry queue behind the front end has
// room, so words may arrive back to back. The back end has one output register
// and emits one result per cycle while the receiver is ready; a header gives one
// result, a byte one per pixel (four on a full group), so the back end sets the
// pace on bitmap data and the queue lets the front take words meanwhile. A word
// goes through the queue and the output register to its first result. The blend
// colors are registered from the color registers, so they change only after the
// color registers have taken an apb write. Registers sit at byte address 0
// (foreground, reset 0xffff) and 4 (background, reset 0x0000); only paddr bit 2
// selects the register, and pready is always high.

module glyph_2bpp_to_rgb565_expander import gtr_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // apb configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    // input words
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic                  i_kind,
    input  logic [5:0]            i_glyph_width,
    input  logic [5:0]            i_glyph_height,
    input  logic signed [16:0]    i_pen_x,
    input  logic signed [7:0]     i_offset_x,
    input  logic signed [15:0]    i_baseline_y,
    input  logic signed [7:0]     i_offset_y,
    input  logic [7:0]            i_bitmap_byte,
    // result words
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic                  o_out_kind,
    output logic [1:0]            o_status,
    output logic [9:0]            o_rect_x,
    output logic [9:0]            o_rect_y,
    output logic [15:0]           o_pixel_color,
    output logic                  o_glyph_end,
    output logic                  o_last
);

    logic [15:0] r_fg;
    logic [15:0] r_bg;
    logic        cfg_wr;

    // queue hookup
    logic   q_push;
    logic   q_pop;
    logic   q_valid;
    logic   q_full;
    t_entry q_wdata;
    t_entry q_rdata;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    // color registers, bit 2 of the address picks one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fg <= FG_RESET;
            r_bg <= BG_RESET;
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_FG:  r_fg <= pwdata[15:0];
                REG_BG:  r_bg <= pwdata[15:0];
                default: r_fg <= r_fg;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_FG:  prdata = {16'd0, r_fg};
            REG_BG:  prdata = {16'd0, r_bg};
            default: prdata = 32'd0;
        endcase
    end

    // front: header checks and glyph position tracking
    gtr_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_kind         (i_kind),
        .i_glyph_width  (i_glyph_width),
        .i_glyph_height (i_glyph_height),
        .i_pen_x        (i_pen_x),
        .i_offset_x     (i_offset_x),
        .i_baseline_y   (i_baseline_y),
        .i_offset_y     (i_offset_y),
        .i_bitmap_byte  (i_bitmap_byte),
        .i_q_full       (q_full),
        .o_push         (q_push),
        .o_entry        (q_wdata)
    );

    // decouples the one-word-per-cycle front from the pixel-per-cycle back, each while not stalled
    gtr_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_wdata (q_wdata),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_full  (q_full),
        .o_rdata (q_rdata)
    );

    // back: palette lookup and result serialization
    gtr_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fg          (r_fg),
        .i_bg          (r_bg),
        .i_q_valid     (q_valid),
        .i_q_entry     (q_rdata),
        .o_pop         (q_pop),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_out_kind    (o_out_kind),
        .o_status      (o_status),
        .o_rect_x      (o_rect_x),
        .o_rect_y      (o_rect_y),
        .o_pixel_color (o_pixel_color),
        .o_glyph_end   (o_glyph_end),
        .o_last        (o_last)
    );

endmodule

### dv/tb.sv
// self-checking testbench for glyph_2bpp_to_rgb565_expander
// depends on gtr_pkg and the expander rtl; drives apb, input and result ports

`timescale 1ns / 1ps

module tb;
    import gtr_pkg::*;

    localparam int CLK_PERIOD    = 20;
    localparam int RESET_CYCLES  = 11;
    localparam int SETTLE_CYCLES = 10;     // output register plus a queue of two
    localparam int HOLD_CYCLES   = 80;     // long result hold-off, fills the queue
    localparam int PHASE_WORDS   = 21;
    localparam int PHASE_COUNT   = 5;
    localparam int CYCLE_LIMIT   = 200000;

    // one input word as the sender sees it
    typedef struct {
        logic               kind;
        logic [5:0]         width;
        logic [5:0]         height;
        logic signed [16:0] pen_x;
        logic signed [7:0]  offset_x;
        logic signed [15:0] baseline_y;
        logic signed [7:0]  offset_y;
        logic [7:0]         bitmap_byte;
    } t_word;

    // one result word
    typedef struct {
        logic        kind;
        logic [1:0]  status;
        logic [9:0]  rect_x;
        logic [9:0]  rect_y;
        logic [15:0] color;
        logic        glyph_end;
        logic        last;
    } t_result;

    // directed stimulus row; header rows carry their status typed in
    typedef struct {
        t_word   w;
        bit      typed;
        t_result status_word;
    } t_dir_row;

    // dut ports
    logic                  i_clk;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;
    logic                  i_valid;
    logic                  o_ready;
    logic                  i_kind;
    logic [5:0]            i_glyph_width;
    logic [5:0]            i_glyph_height;
    logic signed [16:0]    i_pen_x;
    logic signed [7:0]     i_offset_x;
    logic signed [15:0]    i_baseline_y;
    logic signed [7:0]     i_offset_y;
    logic [7:0]            i_bitmap_byte;
    logic                  o_valid;
    logic                  i_ready;
    logic                  o_out_kind;
    logic [1:0]            o_status;
    logic [9:0]            o_rect_x;
    logic [9:0]            o_rect_y;
    logic [15:0]           o_pixel_color;
    logic                  o_glyph_end;
    logic                  o_last;

    // shadow of the block: color registers and glyph walk position
    logic [15:0] fg_shadow = FG_RESET;
    logic [15:0] bg_shadow = BG_RESET;
    bit          glyph_on  = 1'b0;
    int          glyph_w   = 0;
    int          glyph_h   = 0;
    int          glyph_col = 0;
    int          glyph_row = 0;

    // results still owed by the block, oldest first
    t_result     predicted_words[$];
    t_dir_row    dir_rows[$];

    // typed-in status for the word now on offer
    bit          typed_on = 1'b0;
    t_result     typed_result;

    // stimulus control shared with the receiver
    bit          sender_gaps_on   = 1'b1;
    bit          receiver_gaps_on = 1'b1;
    bit          hold_req         = 1'b0;
    int          bytes_left       = 0;   // bitmap bytes still owed to the current glyph

    int          error_count   = 0;
    int          words_sent    = 0;
    int          headers_seen  = 0;
    int          pixels_seen   = 0;
    int          holds_done    = 0;
    int          cycle_count   = 0;

    glyph_2bpp_to_rgb565_expander u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_kind         (i_kind),
        .i_glyph_width  (i_glyph_width),
        .i_glyph_height (i_glyph_height),
        .i_pen_x        (i_pen_x),
        .i_offset_x     (i_offset_x),
        .i_baseline_y   (i_baseline_y),
        .i_offset_y     (i_offset_y),
        .i_bitmap_byte  (i_bitmap_byte),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_out_kind     (o_out_kind),
        .o_status       (o_status),
        .o_rect_x       (o_rect_x),
        .o_rect_y       (o_rect_y),
        .o_pixel_color  (o_pixel_color),
        .o_glyph_end    (o_glyph_end),
        .o_last         (o_last)
    );

    initial i_clk = 1'b0;
    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // ---------------------------------------------------------------
    // prediction
    // ---------------------------------------------------------------

    // palette lookup: background, per-channel thirds (truncated), foreground
    function automatic logic [15:0] blend_565(input logic [1:0] coverage);
        int unsigned a;
        int unsigned r;
        int unsigned g;
        int unsigned b;
        if (coverage == 2'd0) begin
            return bg_shadow;
        end
        if (coverage == 2'd3) begin
            return fg_shadow;
        end
        a = {30'd0, coverage};
        r = (fg_shadow[15:11] * a + bg_shadow[15:11] * (3 - a)) / 3;
        g = (fg_shadow[10:5] * a + bg_shadow[10:5] * (3 - a)) / 3;
        b = (fg_shadow[4:0] * a + bg_shadow[4:0] * (3 - a)) / 3;
        return {r[4:0], g[5:0], b[4:0]};
    endfunction

    // place a header or expand a bitmap byte, queueing what the block owes
    function automatic void expand_word(input t_word w);
        t_result    res;
        logic [1:0] st;
        logic [1:0] coverage;
        int         x;
        int         y;
        int         k;
        int         n;
        bit         done;
        if (w.kind == KIND_HEADER) begin
            x = int'(w.pen_x) + int'(w.offset_x);
            y = int'(w.baseline_y) + int'(w.offset_y);
            // a new header always drops whatever glyph was in flight
            glyph_on = 1'b0;
            // empty wins over too large, too large over off screen
            if (w.width == 0 || w.height == 0) begin
                st = ST_EMPTY;
            end else if (w.width > GLYPH_MAX_W || w.height > GLYPH_MAX_H) begin
                st = ST_TOO_LARGE;
            end else if (x < 0 || y < 0 || x + int'(w.width) > SCREEN_W ||
                         y + int'(w.height) > SCREEN_H) begin
                st = ST_OFF_SCREEN;
            end else begin
                st = ST_OK;
            end
            res.kind      = KIND_HEADER;
            res.status    = st;
            res.rect_x    = (st == ST_OK) ? x[9:0] : 10'd0;
            res.rect_y    = (st == ST_OK) ? y[9:0] : 10'd0;
            res.color     = 16'h0000;
            res.glyph_end = 1'b0;
            res.last      = 1'b1;
            predicted_words.push_back(res);
            if (st == ST_OK) begin
                glyph_on  = 1'b1;
                glyph_w   = int'(w.width);
                glyph_h   = int'(w.height);
                glyph_col = 0;
                glyph_row = 0;
            end
            return;
        end
        // stray bytes with no glyph in flight give nothing
        if (!glyph_on) begin
            return;
        end
        n    = 0;
        done = 1'b0;
        for (k = 0; k < 4; k++) begin
            // pairs past the row width are padding
            if (glyph_col >= glyph_w) begin
                break;
            end
            coverage      = 2'(w.bitmap_byte >> (6 - 2 * k));
            res.kind      = KIND_BYTE;
            res.status    = ST_OK;
            res.rect_x    = 10'd0;
            res.rect_y    = 10'd0;
            res.color     = blend_565(coverage);
            res.glyph_end = 1'b0;
            res.last      = 1'b0;
            predicted_words.push_back(res);
            n++;
            glyph_col++;
        end
        if (glyph_col >= glyph_w) begin
            glyph_col = 0;
            glyph_row++;
            if (glyph_row >= glyph_h) begin
                done      = 1'b1;
                glyph_on  = 1'b0;
                glyph_row = 0;
            end
        end
        if (n > 0) begin
            res           = predicted_words.pop_back();
            res.last      = 1'b1;
            res.glyph_end = done;
            predicted_words.push_back(res);
        end
    endfunction

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            error_count++;
        end
    endfunction

    // ---------------------------------------------------------------
    // monitor: checks results, predicts accepted words, tracks apb writes
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        t_word   seen;
        t_result want;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (predicted_words.size() == 0) begin
                    $error("result word with nothing pending: kind %0d color 0x%0h",
                           o_out_kind, o_pixel_color);
                    error_count++;
                end else begin
                    want = predicted_words.pop_front();
                    check_field("out_kind", 16'(want.kind), 16'(o_out_kind));
                    check_field("status", 16'(want.status), 16'(o_status));
                    check_field("rect_x", 16'(want.rect_x), 16'(o_rect_x));
                    check_field("rect_y", 16'(want.rect_y), 16'(o_rect_y));
                    check_field("pixel_color", want.color, o_pixel_color);
                    check_field("glyph_end", 16'(want.glyph_end), 16'(o_glyph_end));
                    check_field("last", 16'(want.last), 16'(o_last));
                    if (want.kind == KIND_HEADER) begin
                        headers_seen++;
                    end else begin
                        pixels_seen++;
                    end
                end
            end
            if (i_valid && o_ready) begin
                seen.kind        = i_kind;
                seen.width       = i_glyph_width;
                seen.height      = i_glyph_height;
                seen.pen_x       = i_pen_x;
                seen.offset_x    = i_offset_x;
                seen.baseline_y  = i_baseline_y;
                seen.offset_y    = i_offset_y;
                seen.bitmap_byte = i_bitmap_byte;
                expand_word(seen);
                // directed header rows swap in their hand-written status word
                if (typed_on) begin
                    void'(predicted_words.pop_back());
                    predicted_words.push_back(typed_result);
                end
            end
            if (psel && penable && pwrite && pready) begin
                if (paddr[2] == REG_BG) begin
                    bg_shadow = pwdata[15:0];
                end else begin
                    fg_shadow = pwdata[15:0];
                end
            end
        end
    end

    // run-away guard
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // receiver: random stalls per result word, one long hold-off on request
    // ---------------------------------------------------------------
    initial begin
        int gap;
        i_ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                gap      = HOLD_CYCLES;
                holds_done++;
            end else if (receiver_gaps_on) begin
                gap = $urandom_range(0, 6);
            end else begin
                gap = 0;
            end
            if (gap > 0) begin
                i_ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    // ---------------------------------------------------------------
    // sender side
    // ---------------------------------------------------------------

    // offer one word, after a random gap if sender gaps are on, and hold it until taken
    task automatic send_word(input t_word w, input bit typed, input t_result status_word);
        int gap;
        gap = sender_gaps_on ? $urandom_range(0, 6) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        typed_on       = typed;
        typed_result   = status_word;
        i_valid        <= 1'b1;
        i_kind         <= w.kind;
        i_glyph_width  <= w.width;
        i_glyph_height <= w.height;
        i_pen_x        <= w.pen_x;
        i_offset_x     <= w.offset_x;
        i_baseline_y   <= w.baseline_y;
        i_offset_y     <= w.offset_y;
        i_bitmap_byte  <= w.bitmap_byte;
        do @(posedge i_clk); while (!o_ready);
        words_sent++;
    endtask

    // stop offering, let every owed result out, then give a stray byte time to clear
    task automatic wait_until_idle();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (predicted_words.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic sel, input logic [15:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= {16'h0000, value};
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // every field random, so each bit toggles whatever the kind
    function automatic t_word scrambled_word();
        t_word w;
        w.kind        = 1'($urandom_range(0, 1));
        w.width       = 6'($urandom_range(0, 63));
        w.height      = 6'($urandom_range(0, 63));
        w.pen_x       = 17'($urandom);
        w.offset_x    = 8'($urandom_range(0, 255));
        w.baseline_y  = 16'($urandom_range(0, 65535));
        w.offset_y    = 8'($urandom_range(0, 255));
        w.bitmap_byte = 8'($urandom_range(0, 255));
        return w;
    endfunction

    task automatic add_header(input int wd, input int ht, input int px, input int ox,
                              input int by, input int oy, input logic [1:0] st,
                              input int rx, input int ry);
        t_dir_row row;
        row.w.kind                = KIND_HEADER;
        row.w.width               = 6'(wd);
        row.w.height              = 6'(ht);
        row.w.pen_x               = 17'(px);
        row.w.offset_x            = 8'(ox);
        row.w.baseline_y          = 16'(by);
        row.w.offset_y            = 8'(oy);
        row.w.bitmap_byte         = 8'hA5;     // ignored on a header
        row.typed                 = 1'b1;
        row.status_word.kind      = KIND_HEADER;
        row.status_word.status    = st;
        row.status_word.rect_x    = 10'(rx);
        row.status_word.rect_y    = 10'(ry);
        row.status_word.color     = 16'h0000;
        row.status_word.glyph_end = 1'b0;
        row.status_word.last      = 1'b1;
        dir_rows.push_back(row);
    endtask

    task automatic add_byte(input logic [7:0] b);
        t_dir_row row;
        // header fields held at all ones: the block must ignore them
        row.w.kind        = KIND_BYTE;
        row.w.width       = 6'h3F;
        row.w.height      = 6'h3F;
        row.w.pen_x       = '1;
        row.w.offset_x    = '1;
        row.w.baseline_y  = '1;
        row.w.offset_y    = '1;
        row.w.bitmap_byte = b;
        row.typed         = 1'b0;
        row.status_word   = '{default: '0};
        dir_rows.push_back(row);
    endtask

    typedef enum int {
        PICK_BYTE,
        PICK_PLACED,
        PICK_NOISE
    } t_pick;

    // mostly whole glyphs that fit on screen, with stray bytes, junk headers
    // and glyphs cut short by a new header mixed in
    task automatic send_random_word();
        t_word   w;
        t_result none;
        t_pick   pick;
        int      roll;
        int      wd;
        int      ht;
        int      x;
        int      y;
        w    = scrambled_word();
        none = '{default: '0};
        roll = $urandom_range(0, 99);
        if (bytes_left > 0) begin
            pick = (roll < 90) ? PICK_BYTE : (roll < 95) ? PICK_PLACED : PICK_NOISE;
        end else begin
            pick = (roll < 70) ? PICK_PLACED : (roll < 90) ? PICK_NOISE : PICK_BYTE;
        end
        case (pick)
            PICK_BYTE: begin
                w.kind = KIND_BYTE;
                if (bytes_left > 0) begin
                    bytes_left--;
                end
            end
            PICK_PLACED: begin
                // small glyphs mostly, the staging limits now and then
                roll = $urandom_range(0, 19);
                if (roll == 0) begin
                    wd = $urandom_range(1, 4);
                    ht = GLYPH_MAX_H;
                end else if (roll == 1) begin
                    wd = GLYPH_MAX_W;
                    ht = $urandom_range(1, 2);
                end else begin
                    wd = $urandom_range(1, 12);
                    ht = $urandom_range(1, 3);
                end
                // screen edges get their share
                case ($urandom_range(0, 3))
                    0:       x = 0;
                    1:       x = SCREEN_W - wd;
                    default: x = $urandom_range(0, SCREEN_W - wd);
                endcase
                case ($urandom_range(0, 3))
                    0:       y = 0;
                    1:       y = SCREEN_H - ht;
                    default: y = $urandom_range(0, SCREEN_H - ht);
                endcase
                w.kind       = KIND_HEADER;
                w.width      = 6'(wd);
                w.height     = 6'(ht);
                w.pen_x      = 17'(x - int'(w.offset_x));
                w.baseline_y = 16'(y - int'(w.offset_y));
                bytes_left   = ((wd + 3) / 4) * ht;
            end
            default: begin
                w.kind = KIND_HEADER;
                // half the junk headers have a legal size, so they mostly land off screen
                if ($urandom_range(0, 1) == 1) begin
                    w.width  = 6'($urandom_range(1, GLYPH_MAX_W));
                    w.height = 6'($urandom_range(1, GLYPH_MAX_H));
                end
                bytes_left = 0;
            end
        endcase
        send_word(w, 1'b0, none);
    endtask

    // ---------------------------------------------------------------
    // main sequence
    // ---------------------------------------------------------------
    initial begin
        int          phase;
        int          i;
        logic [15:0] fg_pick;
        logic [15:0] bg_pick;

        i_rst_n        = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        i_valid        = 1'b0;
        i_kind         = KIND_HEADER;
        i_glyph_width  = '0;
        i_glyph_height = '0;
        i_pen_x        = '0;
        i_offset_x     = '0;
        i_baseline_y   = '0;
        i_offset_y     = '0;
        i_bitmap_byte  = '0;

        // directed rows, run with the reset colors
        add_byte(8'hFF);                                         // no glyph yet: ignored
        add_header(0, 5, 0, 0, 0, 0, ST_EMPTY, 0, 0);
        add_header(5, 0, 0, 0, 0, 0, ST_EMPTY, 0, 0);
        add_header(0, 63, 0, 0, 0, 0, ST_EMPTY, 0, 0);           // empty beats too large
        add_header(21, 1, 0, 0, 0, 0, ST_TOO_LARGE, 0, 0);
        add_header(1, 25, 0, 0, 0, 0, ST_TOO_LARGE, 0, 0);
        add_header(63, 63, -65536, -128, -32768, -128, ST_TOO_LARGE, 0, 0);
        add_header(4, 2, -1, 0, 0, 0, ST_OFF_SCREEN, 0, 0);      // one left of screen
        add_header(4, 2, 237, 0, 0, 0, ST_OFF_SCREEN, 0, 0);     // one past right edge
        add_header(4, 2, 0, 0, 319, 0, ST_OFF_SCREEN, 0, 0);     // one past bottom edge
        add_header(4, 2, 65535, -128, 0, 0, ST_OFF_SCREEN, 0, 0);
        add_header(4, 2, 0, 0, 32767, 127, ST_OFF_SCREEN, 0, 0);
        add_header(4, 2, 236, 0, 318, 0, ST_OK, 236, 318);      // bottom-right corner fit
        add_byte(8'h1B);                                         // all four coverages
        add_byte(8'hE4);                                         // closes the glyph
        add_byte(8'h55);                                         // after glyph end: ignored
        add_header(5, 2, 10, -10, 5, -5, ST_OK, 0, 0);           // offsets cancel to origin
        add_byte(8'h1B);
        add_byte(8'hC0);                                         // padding pairs dropped
        add_byte(8'hFF);
        add_byte(8'h00);
        add_header(6, 1, 100, 0, 100, 0, ST_OK, 100, 100);
        add_byte(8'hAA);
        add_header(1, 1, 300, -61, 400, -81, ST_OK, 239, 319);   // abandons the 6-wide glyph
        add_byte(8'h80);
        add_header(GLYPH_MAX_W, GLYPH_MAX_H, 0, 0, 0, 0, ST_OK, 0, 0);

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (i = 0; i < dir_rows.size(); i++) begin
            send_word(dir_rows[i].w, dir_rows[i].typed, dir_rows[i].status_word);
        end

        // random part in phases; colors change only once the block has drained,
        // which may fall in the middle of a glyph
        for (phase = 0; phase < PHASE_COUNT; phase++) begin
            wait_until_idle();
            case (phase)
                0: begin
                    fg_pick = 16'h0000;
                    bg_pick = 16'hFFFF;
                end
                1: begin
                    fg_pick = 16'hF800;
                    bg_pick = 16'h001F;
                end
                3: begin
                    fg_pick = 16'hFFFF;
                    bg_pick = 16'hFFFF;
                end
                default: begin
                    fg_pick = 16'($urandom_range(0, 65535));
                    bg_pick = 16'($urandom_range(0, 65535));
                end
            endcase
            apb_write(REG_FG, fg_pick);
            apb_write(REG_BG, bg_pick);
            // phase 0: steady sender against a long result hold-off
            // phase 1: no gaps on either side
            sender_gaps_on   = (phase >= 2);
            receiver_gaps_on = (phase != 1);
            if (phase == 0) begin
                hold_req = 1'b1;
            end
            for (i = 0; i < PHASE_WORDS; i++) begin
                send_random_word();
            end
        end

        wait_until_idle();
        $display("%0d words in, %0d status and %0d pixel results checked",
                 words_sent, headers_seen, pixels_seen);
        $display("%0d color settings, %0d long output hold-off, random gaps on both sides",
                 PHASE_COUNT + 1, holds_done);
        if (error_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
